// ===== rtl/uartrx_pkg.sv =====
// ============================================================================
// uartrx_pkg
// Shared types and codes for the edge-timed UART receive core.
// ============================================================================
package uartrx_pkg;

   // Transaction kinds (req_tuser)
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Bit timer commands
   localparam logic [1:0] TCMD_START   = 2'd0;
   localparam logic [1:0] TCMD_STOP    = 2'd1;
   localparam logic [1:0] TCMD_RESTART = 2'd2;
   localparam logic [1:0] TCMD_NONE    = 2'd3;

   // Frame position codes
   localparam logic signed [5:0] POS_IDLE  = -6'sd2;
   localparam logic signed [5:0] POS_START = -6'sd1;

   // Data bit limits
   localparam logic [3:0] DATA_BITS_MIN   = 4'd5;
   localparam logic [3:0] DATA_BITS_MAX   = 4'd8;
   localparam logic [3:0] DATA_BITS_RESET = 4'd8;

   // Register indexes (word index = paddr[2])
   localparam logic REG_DATA_BITS = 1'b0;

   localparam logic [7:0] FILL_SAT = 8'hFF;

   // Frame assembler result for the current edge
   typedef struct packed {
      logic [1:0] tcmd;
      logic       done;
      logic [7:0] data;
   } frame_res_type;

   // Ring status: empty/full before the step, fill after it
   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] fill;
   } ring_stat_type;

endpackage

// ===== rtl/uart_rx_edge_interval_decoder_core.sv =====
// ============================================================================
// uart_rx_edge_interval_decoder_core
// Edge-timed UART receiver with a byte receive ring.
// ============================================================================
// Rebuilds UART frames (5 to 8 data bits, set by the data_bits register at
// byte address 0, reset 8) from line edge transactions, each carrying the
// line level after the edge and the whole bit periods since the last edge.
// Completed bytes go into a RING_DEPTH-entry ring (holds RING_DEPTH-1 bytes);
// read transactions pop one byte. One transaction is taken every clock while
// the output register is free or being drained; each produces exactly one
// result transaction in the next cycle, held in the output register until taken.
// The ring read goes through the memory's registered read port, which is
// loaded along with the output register. A full ring drops the byte and
// flags overrun; an empty read returns zero with ring_empty set. No clearing
// pass is run after reset: stored entries are read only after being written.
// ============================================================================
module uart_rx_edge_interval_decoder_core #(
   parameter int RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,

   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] line_level, [4:1] bit_periods
   input  logic        req_tuser,   // [0] op (0 edge, 1 read)

   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] timer_cmd, [2] byte_done,
                                    // [10:3] read_byte, [11] ring_empty,
                                    // [12] overrun, [20:13] fill_count

   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   uartrx_pkg::frame_res_type frame_res;
   uartrx_pkg::ring_stat_type ring_stat;

   logic [3:0] data_bits_ff;
   logic       accept, edge_en, read_en, push, pop;
   logic [7:0] ring_rdata;

   // Output register
   logic       rsp_valid_ff;
   logic [1:0] tcmd_ff;
   logic       done_ff, empty_ff, ovr_ff, popped_ff;
   logic [7:0] fill_ff;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == uartrx_pkg::REG_DATA_BITS)
                       ? {28'h0, data_bits_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= uartrx_pkg::DATA_BITS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == uartrx_pkg::REG_DATA_BITS) begin
         data_bits_ff <= csr_pwdata[3:0];
      end
   end

   // ------------------------------------------------------------- handshake
   // New transaction whenever the output slot is free or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign edge_en    = accept && (req_tuser == uartrx_pkg::OP_EDGE);
   assign read_en    = accept && (req_tuser == uartrx_pkg::OP_READ);

   // Push only when the byte completes and there is room; pop if non-empty.
   assign push = edge_en && frame_res.done && !ring_stat.full;
   assign pop  = read_en && !ring_stat.empty;

   uartrx_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .edge_en     (edge_en),
      .line_level  (req_tdata[0]),
      .bit_periods (req_tdata[4:1]),
      .data_bits   (data_bits_ff),
      .res         (frame_res)
   );

   uartrx_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .wdata (frame_res.data),
      .rdata (ring_rdata),
      .stat  (ring_stat)
   );

   // -------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tcmd_ff   <= edge_en ? frame_res.tcmd : uartrx_pkg::TCMD_NONE;
         done_ff   <= edge_en && frame_res.done;
         ovr_ff    <= edge_en && frame_res.done && ring_stat.full;
         empty_ff  <= read_en && ring_stat.empty;
         popped_ff <= pop;
         fill_ff   <= ring_stat.fill;
      end
   end

   // Ring read data lands with the result register; it only reloads on a pop,
   // so it holds while the response is stalled.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, fill_ff, ovr_ff, empty_ff,
                        (popped_ff ? ring_rdata : 8'h00), done_ff, tcmd_ff};

endmodule

// ===== rtl/uartrx_frame.sv =====
// ============================================================================
// uartrx_frame
// Frame assembler: tracks bit position and builds the byte from edge timing.
// ============================================================================
module uartrx_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      edge_en,
   input  logic                      line_level,
   input  logic [3:0]                bit_periods,
   input  logic [3:0]                data_bits,
   output uartrx_pkg::frame_res_type res
);

   logic signed [5:0] pos_ff, pos_in;
   logic [7:0]        byte_ff, byte_in;

   logic [3:0]        nb;
   logic signed [6:0] pos_ext, pos_sum, nb_ext;
   logic [7:0]        mask, byte_new;

   always_comb begin
      priority if (data_bits < uartrx_pkg::DATA_BITS_MIN) begin
         nb = uartrx_pkg::DATA_BITS_MIN;
      end else if (data_bits > uartrx_pkg::DATA_BITS_MAX) begin
         nb = uartrx_pkg::DATA_BITS_MAX;
      end else begin
         nb = data_bits;
      end
   end

   assign pos_ext = {pos_ff[5], pos_ff};
   assign pos_sum = pos_ext + $signed({3'b000, bit_periods});
   assign nb_ext  = $signed({3'b000, nb});

   // Bits covered by the period since the last edge, clipped to the data field
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask[i] = ($signed(7'(i)) < nb_ext) && ($signed(7'(i)) >= pos_ext)
                   && ($signed(7'(i)) < pos_sum);
      end
   end

   assign byte_new = line_level ? byte_ff : (byte_ff | mask);

   always_comb begin
      res.data = byte_new;
      res.done = 1'b0;
      pos_in   = pos_ff;
      byte_in  = byte_ff;
      if (pos_ff == uartrx_pkg::POS_IDLE) begin
         res.tcmd = uartrx_pkg::TCMD_START;
         pos_in   = uartrx_pkg::POS_START;
      end else if (pos_sum >= nb_ext) begin
         res.done = 1'b1;
         byte_in  = 8'h00;
         if (pos_sum > nb_ext) begin
            // edge was also the next start bit
            res.tcmd = uartrx_pkg::TCMD_START;
            pos_in   = uartrx_pkg::POS_START;
         end else begin
            res.tcmd = uartrx_pkg::TCMD_STOP;
            pos_in   = uartrx_pkg::POS_IDLE;
         end
      end else begin
         res.tcmd = uartrx_pkg::TCMD_RESTART;
         pos_in   = pos_sum[5:0];
         byte_in  = byte_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= uartrx_pkg::POS_IDLE;
         byte_ff <= 8'h00;
      end else if (edge_en) begin
         pos_ff  <= pos_in;
         byte_ff <= byte_in;
      end
   end

endmodule

// ===== rtl/uartrx_ring.sv =====
// ============================================================================
// uartrx_ring
// Receive ring: synchronous byte memory with write/read pointers and count.
// ============================================================================
module uartrx_ring #(
   parameter int RING_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      pop,
   input  logic [7:0]                wdata,
   output logic [7:0]                rdata,
   output uartrx_pkg::ring_stat_type stat
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FW = (AW > 8) ? AW : 8;

   logic [7:0]    mem [RING_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [FW-1:0] cnt_wide;
   logic [7:0]    rdata_ff;

   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == AW'(RING_DEPTH - 1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         cnt_in    = cnt_ff + 1'b1;
      end else if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   // Reported fill saturates at 255 for deep rings
   assign cnt_wide  = FW'(cnt_in);
   assign stat.fill = (cnt_wide > FW'(255)) ? uartrx_pkg::FILL_SAT : cnt_wide[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
      if (pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   assign rdata = rdata_ff;

endmodule
